>>> rtl/kfts_pkg.sv
// ----------------------------------------------------------------------------
// kfts_pkg
// Shared widths, codes and command types for the knapsack fitness and
// truncation selection block.
// ----------------------------------------------------------------------------
package kfts_pkg;

    // Field widths
    localparam int CHROM_W     = 40;
    localparam int IDX_W       = 6;
    localparam int ITEM_W      = 8;
    localparam int FIT_W       = 14;
    localparam int CAP_W       = 14;
    localparam int PC_W        = 5;
    localparam int RANK_W      = 4;
    localparam int GRP_W       = 11;
    localparam int GRP_LANES   = 8;
    localparam int MAX_PARENTS = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_COUNT = 1'b1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;
    localparam int CMDQ_CW    = 3;

    typedef enum logic [0:0] {
        KIND_LOAD  = 1'b0,
        KIND_CHROM = 1'b1
    } kfts_kind_t;

    typedef struct packed {
        kfts_kind_t              kind;
        logic                    last;
        logic [IDX_W-1:0]        index;
        logic [ITEM_W-1:0]       weight;
        logic [ITEM_W-1:0]       value;
        logic [CHROM_W-1:0]      chrom;
    } kfts_cmd_t;

    typedef struct packed {
        logic sel_busy;
        logic cmd_pop;
        logic emit;
        logic emit_last;
    } kfts_stat_t;

endpackage

>>> rtl/kfts_front.sv
// ----------------------------------------------------------------------------
// kfts_front
// Accepts input items, classifies them as table loads or chromosomes and
// drops loads whose index lies beyond the item table.
// ----------------------------------------------------------------------------
module kfts_front
    import kfts_pkg::*;
#(
    parameter int N_ITEMS = 40
)
(
    input  logic                push,
    output logic                full,
    input  logic                action,
    input  logic [IDX_W-1:0]    item_index,
    input  logic [ITEM_W-1:0]   item_weight,
    input  logic [ITEM_W-1:0]   item_value,
    input  logic [CHROM_W-1:0]  chromosome,
    input  logic                last,
    input  logic                q_full,
    output logic                q_push,
    output kfts_cmd_t           q_cmd
);

    logic accept;
    logic in_range;
    logic drop;

    // Accept whenever the command queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    // Classify the item and drop loads beyond the table
    assign in_range = ({1'b0, item_index} < (IDX_W + 1)'(N_ITEMS));
    assign drop     = !action && !in_range;
    assign q_push   = accept && !drop;

    always_comb
    begin
        q_cmd.kind   = action ? KIND_CHROM : KIND_LOAD;
        q_cmd.last   = last;
        q_cmd.index  = item_index;
        q_cmd.weight = item_weight;
        q_cmd.value  = item_value;
        q_cmd.chrom  = chromosome;
    end

endmodule

>>> rtl/kfts_fifo.sv
// ----------------------------------------------------------------------------
// kfts_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module kfts_fifo
    import kfts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  kfts_cmd_t   wr_cmd,
    output logic        full,
    input  logic        rd_en,
    output logic        rd_valid,
    output kfts_cmd_t   rd_cmd
);

    kfts_cmd_t            entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg;
    logic [CMDQ_AW-1:0]   rd_ptr_reg;
    logic [CMDQ_CW-1:0]   count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Store the item payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CMDQ_CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CMDQ_CW'(1);
            end
        end
    end

endmodule

>>> rtl/kfts_back.sv
// ----------------------------------------------------------------------------
// kfts_back
// Executes queued items: writes the item tables, evaluates chromosome
// fitness in a registered adder tree, stores the population and runs
// truncation selection into the result register.
// ----------------------------------------------------------------------------
module kfts_back
    import kfts_pkg::*;
#(
    parameter int N_ITEMS  = 40,
    parameter int POP_SIZE = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  kfts_cmd_t            q_cmd,
    output logic                 q_pop,
    input  logic [CAP_W-1:0]     capacity,
    input  logic [PC_W-1:0]      parent_count,
    input  logic                 pop,
    output logic                 empty,
    output logic [RANK_W-1:0]    rank,
    output logic [CHROM_W-1:0]   parent_chromosome,
    output logic [FIT_W-1:0]     parent_fitness,
    output logic                 last_parent,
    output kfts_stat_t           stat
);

    localparam int NG     = (N_ITEMS + GRP_LANES - 1) / GRP_LANES;
    localparam int NLANES = NG * GRP_LANES;
    localparam int AW     = $clog2(POP_SIZE);
    localparam int CW     = $clog2(POP_SIZE + 1);
    localparam int CMPW   = (CW > PC_W) ? CW : PC_W;

    typedef enum logic [1:0] {
        SEL_IDLE,
        SEL_SCAN,
        SEL_FETCH,
        SEL_EMIT
    } sel_state_t;

    // Item tables, one register per lane
    logic [ITEM_W-1:0]  w_tbl_reg [N_ITEMS];
    logic [ITEM_W-1:0]  v_tbl_reg [N_ITEMS];

    // Population memories
    logic [CHROM_W-1:0] pop_mem [POP_SIZE];
    logic [FIT_W-1:0]   fit_mem [POP_SIZE];

    // Fitness pipeline
    logic [ITEM_W-1:0]  lane_w [NLANES];
    logic [ITEM_W-1:0]  lane_v [NLANES];
    logic [GRP_W-1:0]   grp_w  [NG];
    logic [GRP_W-1:0]   grp_v  [NG];
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [CHROM_W-1:0] s1_chrom_reg;
    logic [GRP_W-1:0]   s1_wg_reg [NG];
    logic [GRP_W-1:0]   s1_vg_reg [NG];
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic [CHROM_W-1:0] s2_chrom_reg;
    logic [FIT_W-1:0]   s2_wsum_reg;
    logic [FIT_W-1:0]   s2_vsum_reg;
    logic [FIT_W-1:0]   tot_w;
    logic [FIT_W-1:0]   tot_v;
    logic [FIT_W-1:0]   fit_new;

    // Population bookkeeping and selection
    sel_state_t         state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_new;
    logic               store_wr;
    logic [PC_W-1:0]    want;
    logic [CMPW-1:0]    n_cmp;
    logic [PC_W-1:0]    n_sel;
    logic [PC_W-1:0]    n_reg;
    logic [PC_W-1:0]    k_reg;
    logic [CW-1:0]      scan_addr_reg;
    logic               rd_valid_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic [FIT_W-1:0]   fit_rd_reg;
    logic [CHROM_W-1:0] chrom_rd_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [FIT_W-1:0]   best_fit_reg;
    logic               found_reg;
    logic [POP_SIZE-1:0] taken_reg;
    logic               emit;
    logic               emit_last;
    logic               start_sel;
    logic               last_in_flight;

    // Result register
    logic               out_valid_reg;
    logic [RANK_W-1:0]  out_rank_reg;
    logic [CHROM_W-1:0] out_chrom_reg;
    logic [FIT_W-1:0]   out_fit_reg;
    logic               out_last_reg;

    // Take a queued item only when no selection is pending
    assign last_in_flight = (s1_valid_reg && s1_last_reg) || (s2_valid_reg && s2_last_reg);
    assign q_pop = q_valid && (state_reg == SEL_IDLE) && !last_in_flight;

    // Write the item tables lane by lane
    for (genvar l = 0; l < N_ITEMS; l++)
    begin : g_tbl
        always_ff @(posedge clk)
        begin
            if (q_pop && (q_cmd.kind == KIND_LOAD) && (q_cmd.index == IDX_W'(l)))
            begin
                w_tbl_reg[l] <= q_cmd.weight;
                v_tbl_reg[l] <= q_cmd.value;
            end
        end
    end

    // Mask table entries by the chromosome genes
    for (genvar l = 0; l < NLANES; l++)
    begin : g_lane
        if ((l < N_ITEMS) && (l < CHROM_W))
        begin : g_live
            assign lane_w[l] = q_cmd.chrom[l] ? w_tbl_reg[l] : '0;
            assign lane_v[l] = q_cmd.chrom[l] ? v_tbl_reg[l] : '0;
        end
        else
        begin : g_dead
            assign lane_w[l] = '0;
            assign lane_v[l] = '0;
        end
    end

    // Sum each group of lanes
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_w[g] = '0;
            grp_v[g] = '0;
            for (int j = 0; j < GRP_LANES; j++)
            begin
                grp_w[g] = grp_w[g] + GRP_W'(lane_w[g * GRP_LANES + j]);
                grp_v[g] = grp_v[g] + GRP_W'(lane_v[g * GRP_LANES + j]);
            end
        end
    end

    // Sum the group totals
    always_comb
    begin
        tot_w = '0;
        tot_v = '0;
        for (int g = 0; g < NG; g++)
        begin
            tot_w = tot_w + FIT_W'(s1_wg_reg[g]);
            tot_v = tot_v + FIT_W'(s1_vg_reg[g]);
        end
    end

    // Zero the fitness of overweight chromosomes
    assign fit_new = ({1'b0, s2_wsum_reg} > {1'b0, capacity}) ? '0 : s2_vsum_reg;

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        s1_last_reg  <= q_cmd.last;
        s1_chrom_reg <= q_cmd.chrom;
        for (int g = 0; g < NG; g++)
        begin
            s1_wg_reg[g] <= grp_w[g];
            s1_vg_reg[g] <= grp_v[g];
        end
        s2_last_reg  <= s1_last_reg;
        s2_chrom_reg <= s1_chrom_reg;
        s2_wsum_reg  <= tot_w;
        s2_vsum_reg  <= tot_v;
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop && (q_cmd.kind == KIND_CHROM);
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Store decision and selection size
    assign store_wr  = s2_valid_reg && (count_reg < CW'(POP_SIZE));
    assign count_new = store_wr ? (count_reg + CW'(1)) : count_reg;
    assign start_sel = s2_valid_reg && s2_last_reg;
    assign want      = (parent_count > PC_W'(MAX_PARENTS)) ? PC_W'(MAX_PARENTS) : parent_count;
    assign n_cmp     = (CMPW'(want) < CMPW'(count_new)) ? CMPW'(want) : CMPW'(count_new);
    assign n_sel     = n_cmp[PC_W-1:0];

    // Population memories: write on store, registered reads
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            pop_mem[count_reg[AW-1:0]] <= s2_chrom_reg;
            fit_mem[count_reg[AW-1:0]] <= fit_new;
        end
        fit_rd_reg   <= fit_mem[scan_addr_reg[AW-1:0]];
        chrom_rd_reg <= pop_mem[best_idx_reg];
    end

    assign emit      = (state_reg == SEL_EMIT) && (!out_valid_reg || pop);
    assign emit_last = emit && ((k_reg + PC_W'(1)) == n_reg);

    // Selection sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEL_IDLE;
            count_reg     <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            best_idx_reg  <= '0;
            best_fit_reg  <= '0;
            found_reg     <= 1'b0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_rank_reg  <= '0;
            out_chrom_reg <= '0;
            out_fit_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless a new one replaces it
            if (pop && out_valid_reg && !emit)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                SEL_IDLE:
                begin
                    if (start_sel)
                    begin
                        n_reg         <= n_sel;
                        k_reg         <= '0;
                        scan_addr_reg <= '0;
                        rd_valid_reg  <= 1'b0;
                        found_reg     <= 1'b0;
                        taken_reg     <= '0;
                        if (n_sel == '0)
                        begin
                            count_reg <= '0;
                        end
                        else
                        begin
                            count_reg <= count_new;
                            state_reg <= SEL_SCAN;
                        end
                    end
                    else
                    begin
                        count_reg <= count_new;
                    end
                end

                SEL_SCAN:
                begin
                    // Issue one read per cycle
                    if (scan_addr_reg < count_reg)
                    begin
                        rd_valid_reg  <= 1'b1;
                        rd_idx_reg    <= scan_addr_reg[AW-1:0];
                        scan_addr_reg <= scan_addr_reg + CW'(1);
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b0;
                    end
                    // Keep the fittest untaken entry, earliest on ties
                    if (rd_valid_reg && !taken_reg[rd_idx_reg] &&
                        (!found_reg || (fit_rd_reg > best_fit_reg)))
                    begin
                        best_idx_reg <= rd_idx_reg;
                        best_fit_reg <= fit_rd_reg;
                        found_reg    <= 1'b1;
                    end
                    if ((scan_addr_reg >= count_reg) && !rd_valid_reg)
                    begin
                        state_reg <= SEL_FETCH;
                    end
                end

                SEL_FETCH:
                begin
                    state_reg <= SEL_EMIT;
                end

                SEL_EMIT:
                begin
                    if (emit)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_rank_reg           <= k_reg[RANK_W-1:0];
                        out_chrom_reg          <= chrom_rd_reg;
                        out_fit_reg            <= best_fit_reg;
                        out_last_reg           <= emit_last;
                        taken_reg[best_idx_reg] <= 1'b1;
                        k_reg                  <= k_reg + PC_W'(1);
                        scan_addr_reg          <= '0;
                        rd_valid_reg           <= 1'b0;
                        found_reg              <= 1'b0;
                        if (emit_last)
                        begin
                            count_reg <= '0;
                            state_reg <= SEL_IDLE;
                        end
                        else
                        begin
                            state_reg <= SEL_SCAN;
                        end
                    end
                end

                default:
                begin
                    state_reg <= SEL_IDLE;
                end
            endcase
        end
    end

    assign empty             = !out_valid_reg;
    assign rank              = out_rank_reg;
    assign parent_chromosome = out_chrom_reg;
    assign parent_fitness    = out_fit_reg;
    assign last_parent       = out_last_reg;

    always_comb
    begin
        stat.sel_busy  = (state_reg != SEL_IDLE);
        stat.cmd_pop   = q_pop;
        stat.emit      = emit;
        stat.emit_last = emit_last;
    end

endmodule

>>> rtl/knapsack_fitness_top_select.sv
// A chromosome passes the command queue and the fitness stages s1 and s2 before it
// is stored; the first parent follows the scan, fetch and emit states of selection.
// Throughput: one item per cycle while loading and the command queue has room;
// selection then walks the fitness memory once for each parent emitted.
// Input stalls during selection once the four-entry command queue is full.
// Reset: rst_n clears control, registers return to capacity 100, parents 8.
// ----------------------------------------------------------------------------
// knapsack_fitness_top_select
// Knapsack fitness evaluation with truncation selection of the fittest
// chromosomes; front classifier, command queue and execution back end.
// ----------------------------------------------------------------------------
module knapsack_fitness_top_select
    import kfts_pkg::*;
#(
    parameter int N_ITEMS  = 40,
    parameter int POP_SIZE = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   action,
    input  logic [IDX_W-1:0]       item_index,
    input  logic [ITEM_W-1:0]      item_weight,
    input  logic [ITEM_W-1:0]      item_value,
    input  logic [CHROM_W-1:0]     chromosome,
    input  logic                   last,
    output logic                   empty,
    input  logic                   pop,
    output logic [RANK_W-1:0]      rank,
    output logic [CHROM_W-1:0]     parent_chromosome,
    output logic [FIT_W-1:0]       parent_fitness,
    output logic                   last_parent,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CAP_W-1:0] capacity_reg;
    logic [PC_W-1:0]  parent_count_reg;
    logic             q_full;
    logic             q_push;
    kfts_cmd_t        q_wr_cmd;
    logic             q_valid;
    logic             q_pop;
    kfts_cmd_t        q_rd_cmd;
    kfts_stat_t       stat;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= CAP_W'(100);
            parent_count_reg <= PC_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CAPACITY:     capacity_reg     <= cfg_data[CAP_W-1:0];
                REG_PARENT_COUNT: parent_count_reg <= cfg_data[PC_W-1:0];
                default:          capacity_reg     <= capacity_reg;
            endcase
        end
    end

    kfts_front #(
        .N_ITEMS (N_ITEMS)
    ) u_front (
        .push        (push),
        .full        (full),
        .action      (action),
        .item_index  (item_index),
        .item_weight (item_weight),
        .item_value  (item_value),
        .chromosome  (chromosome),
        .last        (last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_wr_cmd)
    );

    kfts_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_cmd   (q_wr_cmd),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_rd_cmd)
    );

    kfts_back #(
        .N_ITEMS  (N_ITEMS),
        .POP_SIZE (POP_SIZE)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_cmd             (q_rd_cmd),
        .q_pop             (q_pop),
        .capacity          (capacity_reg),
        .parent_count      (parent_count_reg),
        .pop               (pop),
        .empty             (empty),
        .rank              (rank),
        .parent_chromosome (parent_chromosome),
        .parent_fitness    (parent_fitness),
        .last_parent       (last_parent),
        .stat              (stat)
    );

`ifndef ASSERT_OFF
    // No new item enters the back end while a selection runs
    a_no_pop_in_sel: assert property (@(posedge clk) disable iff (!rst_n)
        stat.sel_busy |-> !stat.cmd_pop)
        else $error("item taken from queue during selection");

    // A new parent never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.emit |-> (empty || pop))
        else $error("result register overwritten");

    // Selection ends only with the final parent
    a_sel_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(stat.sel_busy) |-> $past(stat.emit_last))
        else $error("selection ended without final parent");
`endif

endmodule

>>> test/kfts_parent_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfts_parent_checker
// Watches the item, parent and register channels of the knapsack selection
// block. It keeps its own item tables, population and registers, scores each
// chromosome, ranks the population on the last one and compares every
// parent that leaves the block with the oldest parent still owed.
// ----------------------------------------------------------------------------
module kfts_parent_checker
    import kfts_pkg::*;
#(
    parameter int N_ITEMS  = 40,
    parameter int POP_SIZE = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  logic                   action,
    input  logic [IDX_W-1:0]       item_index,
    input  logic [ITEM_W-1:0]      item_weight,
    input  logic [ITEM_W-1:0]      item_value,
    input  logic [CHROM_W-1:0]     chromosome,
    input  logic                   last,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [RANK_W-1:0]      rank,
    input  logic [CHROM_W-1:0]     parent_chromosome,
    input  logic [FIT_W-1:0]       parent_fitness,
    input  logic                   last_parent,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fault_count,
    output int                     parents_outstanding
);

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [CHROM_W-1:0] chrom;
        logic [FIT_W-1:0]   fitness;
        logic               final_one;
    } parent_t;

    logic [ITEM_W-1:0]  weight_tab [N_ITEMS];
    logic [ITEM_W-1:0]  value_tab  [N_ITEMS];
    logic [CHROM_W-1:0] chrom_store [POP_SIZE];
    logic [FIT_W-1:0]   fit_store   [POP_SIZE];
    int unsigned        stored;
    logic [CAP_W-1:0]   capacity;
    logic [PC_W-1:0]    parent_count;
    parent_t            parents_due [$];

    // Sum the values of the selected items; zero when overweight
    function automatic logic [FIT_W-1:0] score_chromosome(input logic [CHROM_W-1:0] chrom);
        int unsigned wsum;
        int unsigned vsum;
        wsum = 0;
        vsum = 0;
        for (int i = 0; i < N_ITEMS && i < CHROM_W; i++)
        begin
            if (chrom[i])
            begin
                wsum += weight_tab[i];
                vsum += value_tab[i];
            end
        end
        if (wsum > capacity)
            return '0;
        return FIT_W'(vsum);
    endfunction

    // Pick the fittest stored chromosomes, ties to the earlier slot, then empty the population
    function automatic void rank_parents();
        int unsigned want;
        int unsigned n;
        int unsigned best;
        bit          found;
        logic [POP_SIZE-1:0] taken;
        parent_t     p;
        want  = (parent_count > MAX_PARENTS) ? MAX_PARENTS : parent_count;
        n     = (want < stored) ? want : stored;
        taken = '0;
        for (int k = 0; k < n; k++)
        begin
            best  = 0;
            found = 1'b0;
            for (int i = 0; i < stored; i++)
            begin
                if (!taken[i] && (!found || fit_store[i] > fit_store[best]))
                begin
                    best  = i;
                    found = 1'b1;
                end
            end
            taken[best] = 1'b1;
            p.rank      = RANK_W'(k);
            p.chrom     = chrom_store[best];
            p.fitness   = fit_store[best];
            p.final_one = (k + 1 == n);
            parents_due = {parents_due, p};
        end
        stored = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parent_t owed;
        if (!rst_n)
        begin
            capacity     = CAP_W'(100);
            parent_count = PC_W'(8);
            stored       = 0;
            fault_count  = 0;
            parents_due.delete();
            for (int i = 0; i < N_ITEMS; i++)
            begin
                weight_tab[i] = '0;
                value_tab[i]  = '0;
            end
        end
        else
        begin
            // Compare an accepted parent with the oldest one owed
            if (pop && !empty)
            begin
                if (parents_due.size() == 0)
                begin
                    $error("unexpected parent: rank %0d chromosome %h fitness %0d",
                           rank, parent_chromosome, parent_fitness);
                    fault_count++;
                end
                else
                begin
                    owed = parents_due.pop_front();
                    if (rank !== owed.rank)
                    begin
                        $error("rank: expected %0d, actual %0d", owed.rank, rank);
                        fault_count++;
                    end
                    if (parent_chromosome !== owed.chrom)
                    begin
                        $error("parent_chromosome: expected %h, actual %h",
                               owed.chrom, parent_chromosome);
                        fault_count++;
                    end
                    if (parent_fitness !== owed.fitness)
                    begin
                        $error("parent_fitness: expected %0d, actual %0d",
                               owed.fitness, parent_fitness);
                        fault_count++;
                    end
                    if (last_parent !== owed.final_one)
                    begin
                        $error("last_parent: expected %0b, actual %0b",
                               owed.final_one, last_parent);
                        fault_count++;
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CAPACITY)
                    capacity = cfg_data[CAP_W-1:0];
                else if (cfg_index == REG_PARENT_COUNT)
                    parent_count = cfg_data[PC_W-1:0];
            end

            // Load a table entry or score and store a chromosome
            if (push && !full)
            begin
                if (kfts_kind_t'(action) == KIND_LOAD)
                begin
                    if (item_index < N_ITEMS)
                    begin
                        weight_tab[item_index] = item_weight;
                        value_tab[item_index]  = item_value;
                    end
                end
                else
                begin
                    if (stored < POP_SIZE)
                    begin
                        chrom_store[stored] = chromosome;
                        fit_store[stored]   = score_chromosome(chromosome);
                        stored++;
                    end
                    if (last)
                        rank_parents();
                end
            end
        end
        parents_outstanding = parents_due.size();
    end

endmodule

>>> test/knapsack_fitness_top_select_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knapsack_fitness_top_select_test
// Fills the item tables, runs corner populations and then random populations
// under several capacity and parent count settings, with idle gaps on both
// sides, a long output hold-off and drained pauses. Checking is done by
// kfts_parent_checker; this module drives the block and gives the verdict.
// ----------------------------------------------------------------------------
module knapsack_fitness_top_select_test;
    import kfts_pkg::*;

    localparam int N_ITEMS       = 40;
    localparam int POP_SIZE      = 16;
    localparam int QUIET_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTING_ITEMS = 4;

    // Corner chromosomes run under capacity 100 and eight parents
    localparam logic [CHROM_W-1:0] CORNER_CHROMS [7] = '{
        40'h00_0000_0000,   // nothing selected
        40'hFF_FFFF_FFFF,   // everything selected, far overweight
        40'h00_0000_0001,   // weightless item of top value
        40'h00_0000_0002,   // single item over capacity
        40'h00_0000_0004,   // weight exactly at capacity
        40'h80_0000_0000,   // highest item
        40'h00_0000_0001    // ties the earlier slot
    };

    // Register plan for the random part: four settings per idle phase, -1 draws at random
    localparam int CAP_PLAN [12] = '{100, 16383, 0, -1, 300, 16383, -1, 1000, -1, 16383, 50, -1};
    localparam int PC_PLAN  [12] = '{8, 16, 1, -1, 0, 31, 5, 16, 20, 16, 3, -1};

    logic                   clk;
    logic                   rst_n       = 1'b0;
    logic                   push        = 1'b0;
    logic                   full;
    logic                   action      = 1'b0;
    logic [IDX_W-1:0]       item_index  = '0;
    logic [ITEM_W-1:0]      item_weight = '0;
    logic [ITEM_W-1:0]      item_value  = '0;
    logic [CHROM_W-1:0]     chromosome  = '0;
    logic                   last        = 1'b0;
    logic                   empty;
    logic                   pop         = 1'b0;
    logic [RANK_W-1:0]      rank;
    logic [CHROM_W-1:0]     parent_chromosome;
    logic [FIT_W-1:0]       parent_fitness;
    logic                   last_parent;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    int fault_count;
    int parents_outstanding;
    int items_sent    = 0;
    int tx_idle_pct   = 36;
    int rx_idle_pct   = 63;
    int stall_cycles  = 0;
    bit hold_request  = 1'b0;

    knapsack_fitness_top_select #(
        .N_ITEMS  (N_ITEMS),
        .POP_SIZE (POP_SIZE)
    ) dut (.*);

    kfts_parent_checker #(
        .N_ITEMS  (N_ITEMS),
        .POP_SIZE (POP_SIZE)
    ) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly light weights so that selections often fit
    function automatic logic [ITEM_W-1:0] random_weight();
        if ($urandom_range(0, 3) == 0)
            return ITEM_W'($urandom_range(0, 255));
        return ITEM_W'($urandom_range(0, 31));
    endfunction

    // Chromosomes of mixed density, from single items to all items
    function automatic logic [CHROM_W-1:0] random_chromosome();
        logic [CHROM_W-1:0] c;
        c = CHROM_W'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: c = c & CHROM_W'({$urandom, $urandom});
            1: c = c & CHROM_W'({$urandom, $urandom}) & CHROM_W'({$urandom, $urandom});
            2: c = CHROM_W'(1) << $urandom_range(0, N_ITEMS - 1);
            3: c = ($urandom_range(0, 1) == 1) ? '1 : '0;
            4: ;
            default: c = c & CHROM_W'({$urandom, $urandom}) & CHROM_W'({$urandom, $urandom})
                           & CHROM_W'({$urandom, $urandom});
        endcase
        return c;
    endfunction

    // Offer one item, idling at random first; push stays high on return
    task automatic send_item(input kfts_kind_t kind, input logic [IDX_W-1:0] idx,
                             input logic [ITEM_W-1:0] w, input logic [ITEM_W-1:0] v,
                             input logic [CHROM_W-1:0] chrom, input logic lst);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        action      <= kind;
        item_index  <= idx;
        item_weight <= w;
        item_value  <= v;
        chromosome  <= chrom;
        last        <= lst;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    // One population with the odd table load mixed in, last on the final chromosome
    task automatic send_population(input int size);
        for (int j = 0; j < size; j++)
        begin
            if ($urandom_range(0, 99) < 12)
                send_item(KIND_LOAD, IDX_W'($urandom_range(0, 63)), random_weight(),
                          ITEM_W'($urandom_range(0, 255)), random_chromosome(),
                          1'($urandom_range(0, 1)));
            send_item(KIND_CHROM, IDX_W'($urandom_range(0, 63)),
                      ITEM_W'($urandom_range(0, 255)), ITEM_W'($urandom_range(0, 255)),
                      random_chromosome(), j == size - 1);
        end
    endtask

    // Stop offering, wait for every owed parent, then let selection wind down
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (parents_outstanding != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int cap, input int pc);
        settle();
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_PARENT_COUNT, pc);
    endtask

    // Result side: random pops, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [ITEM_W-1:0] w;
        logic [ITEM_W-1:0] v;
        int cap;
        int pc;
        int target;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every table entry; the first few hold the extremes
        for (int i = 0; i < N_ITEMS; i++)
        begin
            case (i)
                0:
                begin
                    w = 8'd0;
                    v = 8'd255;
                end
                1:
                begin
                    w = 8'd255;
                    v = 8'd255;
                end
                2:
                begin
                    w = 8'd100;
                    v = 8'd0;
                end
                3:
                begin
                    w = 8'd255;
                    v = 8'd0;
                end
                default:
                begin
                    w = random_weight();
                    v = ITEM_W'($urandom_range(0, 255));
                end
            endcase
            send_item(KIND_LOAD, IDX_W'(i), w, v, random_chromosome(),
                      1'($urandom_range(0, 1)));
        end

        // Loads past the table end must change nothing
        send_item(KIND_LOAD, 6'd40, 8'd255, 8'd255, '1, 1'b1);
        send_item(KIND_LOAD, 6'd63, 8'd255, 8'd255, '0, 1'b0);

        // Corner chromosomes as a short population
        for (int i = 0; i < 7; i++)
            send_item(KIND_CHROM, IDX_W'($urandom_range(0, 63)),
                      ITEM_W'($urandom_range(0, 255)), ITEM_W'($urandom_range(0, 255)),
                      CORNER_CHROMS[i], i == 6);

        // Overfill the population; the extra chromosomes drop, the last one still selects
        configure(100, 16);
        for (int i = 0; i < POP_SIZE + 2; i++)
            send_item(KIND_CHROM, IDX_W'($urandom_range(0, 63)),
                      ITEM_W'($urandom_range(0, 255)), ITEM_W'($urandom_range(0, 255)),
                      random_chromosome(), i == POP_SIZE + 1);

        // No parents wanted: the population still resets
        configure(100, 0);
        send_item(KIND_CHROM, '0, '0, '0, 40'h1, 1'b0);
        send_item(KIND_CHROM, '0, '0, '0, 40'h5, 1'b1);

        // Random populations through three idle phases
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 63 : 0;
            rx_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 36 : 0;
            for (int s = 0; s < 4; s++)
            begin
                cap = CAP_PLAN[phase * 4 + s];
                pc  = PC_PLAN[phase * 4 + s];
                if (cap < 0)
                    cap = $urandom_range(0, 2000);
                if (pc < 0)
                    pc = $urandom_range(1, 16);
                configure(cap, pc);
                // Hold the result side while full populations keep coming
                if (phase == 2 && s == 1)
                begin
                    hold_request = 1'b1;
                    repeat (2) send_population(POP_SIZE);
                end
                target = items_sent + SETTING_ITEMS;
                while (items_sent < target)
                begin
                    if ($urandom_range(0, 99) < 85)
                        send_population($urandom_range(1, POP_SIZE / 2));
                    else
                        send_population($urandom_range(POP_SIZE + 1, POP_SIZE + 4));
                end
            end
        end

        settle();
        if (fault_count == 0 && parents_outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
